/* rtl/core/usb_ep0_pkg.sv */
// package: types, codes and descriptor lengths for the ep0 standard request handler
`timescale 1ns / 1ps
`default_nettype none

package usb_ep0_pkg;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        FUNC_SETUP     = 2'd0,
        FUNC_BUS_RESET = 2'd1,
        FUNC_EMPTY     = 2'd2
    } t_func;

    // result actions
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SEND       = 3'd1,
        ACT_ACK        = 3'd2,
        ACT_IGNORE     = 3'd3,
        ACT_ACK_IGNORE = 3'd4
    } t_action;

    // device state
    typedef enum logic [1:0] {
        ST_INITIAL      = 2'd0,
        ST_UNCONFIGURED = 2'd1,
        ST_CONFIGURED   = 2'd2
    } t_dev_state;

    // descriptor selection
    typedef enum logic [2:0] {
        DESC_DEVICE    = 3'd0,
        DESC_CONFIG    = 3'd1,
        DESC_LANGID    = 3'd2,
        DESC_MAKER     = 3'd3,
        DESC_PRODUCT   = 3'd4,
        DESC_SERIAL    = 3'd5,
        DESC_INTERFACE = 3'd6,
        DESC_CFG_VALUE = 3'd7
    } t_desc_sel;

    // standard request codes
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    // descriptor type codes in the wValue high byte
    localparam logic [7:0] DTYPE_DEVICE = 8'd1;
    localparam logic [7:0] DTYPE_CONFIG = 8'd2;
    localparam logic [7:0] DTYPE_STRING = 8'd3;

    // string indexes
    localparam logic [7:0] STR_LANGID    = 8'd0;
    localparam logic [7:0] STR_MAKER     = 8'd1;
    localparam logic [7:0] STR_PRODUCT   = 8'd2;
    localparam logic [7:0] STR_SERIAL    = 8'd3;
    localparam logic [7:0] STR_INTERFACE = 8'd5;

    // address limits and lengths
    localparam int          ADDR_W         = 7;
    localparam logic [15:0] ADDR_LIMIT     = 16'd255;
    localparam logic [15:0] CONFIG_SET_LEN = 16'h0020;

    // input item
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [7:0]  value_low;
        logic [7:0]  value_high;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_req;

    // result item
    typedef struct packed {
        t_action           action;
        t_desc_sel         descriptor_select;
        logic [15:0]       send_length;
        logic [ADDR_W-1:0] device_address;
        t_dev_state        device_state;
        logic              data_endpoint_enabled;
    } t_rsp;

    // byte length of each descriptor
    function automatic logic [15:0] desc_len(input t_desc_sel sel);
        logic [15:0] len;
        case (sel)
            DESC_DEVICE:    len = 16'd18;
            DESC_CONFIG:    len = CONFIG_SET_LEN;
            DESC_LANGID:    len = 16'd4;
            DESC_MAKER:     len = 16'd18;
            DESC_PRODUCT:   len = 16'd36;
            DESC_SERIAL:    len = 16'd18;
            DESC_INTERFACE: len = 16'd30;
            DESC_CFG_VALUE: len = 16'd1;
            default:        len = 16'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/usb_ep0_in_reg.sv */
// input register stage: holds one request until the execute step takes it
`timescale 1ns / 1ps
`default_nettype none

module usb_ep0_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire usb_ep0_pkg::t_req i_req,
    input  wire logic              i_advance,
    output logic                   o_stall,
    output logic                   o_valid,
    output usb_ep0_pkg::t_req      o_req
);

    logic              r_valid;
    usb_ep0_pkg::t_req r_req;
    logic              w_load;

    // stage can take a transfer when empty or when its item moves on
    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

/* rtl/core/usb_ep0_exec.sv */
// request decode and device state registers
`timescale 1ns / 1ps
`default_nettype none

module usb_ep0_exec (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire usb_ep0_pkg::t_req i_req,
    output usb_ep0_pkg::t_rsp      o_rsp
);

    usb_ep0_pkg::t_dev_state                r_state, n_state;
    logic [usb_ep0_pkg::ADDR_W-1:0]         r_addr, n_addr;
    logic                                   r_ep_en, n_ep_en;

    usb_ep0_pkg::t_action   w_action;
    usb_ep0_pkg::t_desc_sel w_sel;
    logic [15:0]            w_len;
    logic                   w_desc_ok;
    usb_ep0_pkg::t_desc_sel w_desc_sel;
    logic [15:0]            w_addr16;
    logic [15:0]            w_dlen;

    // state registers, updated as each item is retired
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usb_ep0_pkg::ST_INITIAL;
            r_addr  <= '0;
            r_ep_en <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_ep_en <= n_ep_en;
        end
    end

    // descriptor lookup from type and index
    always_comb begin
        w_desc_ok  = 1'b0;
        w_desc_sel = usb_ep0_pkg::DESC_DEVICE;
        case (i_req.value_high)
            usb_ep0_pkg::DTYPE_DEVICE: begin
                w_desc_ok  = 1'b1;
                w_desc_sel = usb_ep0_pkg::DESC_DEVICE;
            end
            usb_ep0_pkg::DTYPE_CONFIG: begin
                w_desc_ok  = 1'b1;
                w_desc_sel = usb_ep0_pkg::DESC_CONFIG;
            end
            usb_ep0_pkg::DTYPE_STRING: begin
                w_desc_ok = 1'b1;
                case (i_req.value_low)
                    usb_ep0_pkg::STR_LANGID:    w_desc_sel = usb_ep0_pkg::DESC_LANGID;
                    usb_ep0_pkg::STR_MAKER:     w_desc_sel = usb_ep0_pkg::DESC_MAKER;
                    usb_ep0_pkg::STR_PRODUCT:   w_desc_sel = usb_ep0_pkg::DESC_PRODUCT;
                    usb_ep0_pkg::STR_SERIAL:    w_desc_sel = usb_ep0_pkg::DESC_SERIAL;
                    usb_ep0_pkg::STR_INTERFACE: w_desc_sel = usb_ep0_pkg::DESC_INTERFACE;
                    default:                    w_desc_ok  = 1'b0;
                endcase
            end
            default: begin
                w_desc_ok = 1'b0;
            end
        endcase
    end

    // descriptor length to clamp against the host's request
    assign w_dlen   = usb_ep0_pkg::desc_len(w_desc_sel);
    assign w_addr16 = {i_req.value_high, i_req.value_low};

    // next state and action
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_ep_en  = r_ep_en;
        w_action = usb_ep0_pkg::ACT_NONE;
        w_sel    = usb_ep0_pkg::DESC_DEVICE;
        w_len    = 16'd0;
        case (i_req.func)
            usb_ep0_pkg::FUNC_BUS_RESET: begin
                n_state = usb_ep0_pkg::ST_INITIAL;
                n_addr  = '0;
                n_ep_en = 1'b0;
            end
            usb_ep0_pkg::FUNC_SETUP: begin
                w_action = usb_ep0_pkg::ACT_IGNORE;
                case (i_req.request_code)
                    usb_ep0_pkg::REQ_GET_DESCRIPTOR: begin
                        if (w_desc_ok) begin
                            w_action = usb_ep0_pkg::ACT_SEND;
                            w_sel    = w_desc_sel;
                            w_len    = (w_dlen < i_req.request_length) ?
                                       w_dlen : i_req.request_length;
                        end
                    end
                    usb_ep0_pkg::REQ_SET_ADDRESS: begin
                        if (i_req.request_index == 16'd0 && i_req.request_length == 16'd0 &&
                            w_addr16 < usb_ep0_pkg::ADDR_LIMIT) begin
                            case (r_state)
                                usb_ep0_pkg::ST_INITIAL: begin
                                    w_action = usb_ep0_pkg::ACT_ACK;
                                    if (w_addr16 != 16'd0) begin
                                        n_addr  = w_addr16[usb_ep0_pkg::ADDR_W-1:0];
                                        n_state = usb_ep0_pkg::ST_CONFIGURED;
                                    end
                                end
                                usb_ep0_pkg::ST_UNCONFIGURED: begin
                                    w_action = usb_ep0_pkg::ACT_ACK;
                                    if (w_addr16 != 16'd0) begin
                                        n_addr = w_addr16[usb_ep0_pkg::ADDR_W-1:0];
                                    end else begin
                                        n_addr  = '0;
                                        n_state = usb_ep0_pkg::ST_INITIAL;
                                    end
                                end
                                usb_ep0_pkg::ST_CONFIGURED: begin
                                    if (w_addr16 == 16'd0) begin
                                        w_action = usb_ep0_pkg::ACT_ACK;
                                        n_addr   = '0;
                                        n_state  = usb_ep0_pkg::ST_INITIAL;
                                    end else begin
                                        w_action = usb_ep0_pkg::ACT_ACK_IGNORE;
                                    end
                                end
                                default: begin
                                    w_action = usb_ep0_pkg::ACT_NONE;
                                end
                            endcase
                        end
                    end
                    usb_ep0_pkg::REQ_GET_CONFIG: begin
                        if (r_state == usb_ep0_pkg::ST_CONFIGURED && w_addr16 == 16'd0 &&
                            i_req.request_index == 16'd0 &&
                            i_req.request_length[7:0] == 8'd1) begin
                            w_action = usb_ep0_pkg::ACT_SEND;
                            w_sel    = usb_ep0_pkg::DESC_CFG_VALUE;
                            w_len    = 16'd1;
                        end
                    end
                    usb_ep0_pkg::REQ_SET_CONFIG: begin
                        if (i_req.request_index == 16'd0 && i_req.request_length == 16'd0 &&
                            i_req.request_type == 8'd0 && i_req.value_high == 8'd0) begin
                            if (r_state == usb_ep0_pkg::ST_UNCONFIGURED) begin
                                if (i_req.value_low == 8'd1) begin
                                    n_ep_en  = 1'b1;
                                    n_state  = usb_ep0_pkg::ST_CONFIGURED;
                                    w_action = usb_ep0_pkg::ACT_ACK;
                                end else if (i_req.value_low == 8'd0) begin
                                    w_action = usb_ep0_pkg::ACT_ACK;
                                end
                            end else if (r_state == usb_ep0_pkg::ST_CONFIGURED) begin
                                if (i_req.value_low == 8'd1) begin
                                    w_action = usb_ep0_pkg::ACT_ACK;
                                end else if (i_req.value_low == 8'd0) begin
                                    n_ep_en  = 1'b0;
                                    n_state  = usb_ep0_pkg::ST_UNCONFIGURED;
                                    w_action = usb_ep0_pkg::ACT_ACK;
                                end
                            end
                        end
                    end
                    default: begin
                        w_action = usb_ep0_pkg::ACT_IGNORE;
                    end
                endcase
            end
            default: begin
                // empty packet and unused code: nothing changes
                w_action = usb_ep0_pkg::ACT_NONE;
            end
        endcase
    end

    // result carries the state after this item
    always_comb begin
        o_rsp.action                = w_action;
        o_rsp.descriptor_select     = w_sel;
        o_rsp.send_length           = w_len;
        o_rsp.device_address        = n_addr;
        o_rsp.device_state          = n_state;
        o_rsp.data_endpoint_enabled = n_ep_en;
    end

endmodule

`default_nettype wire

/* rtl/core/usb_ep0_out_reg.sv */
// result register: holds one result until the sink takes the transfer
`timescale 1ns / 1ps
`default_nettype none

module usb_ep0_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire usb_ep0_pkg::t_rsp i_rsp,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output usb_ep0_pkg::t_rsp      o_rsp
);

    logic              r_valid;
    usb_ep0_pkg::t_rsp r_rsp;

    // free when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

/* rtl/core/usb_ep0_standard_request_handler.sv */
// top level: usb control endpoint zero standard request handler
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   request | in        | i_in_valid / o_in_stall   | i_in_data  (t_req)
//   result  | out       | o_out_valid / i_out_stall | o_out_data (t_rsp)
//
// one item per cycle sustained while the result is not stalled; the item sits in
// the input register while the decode and state update run, then in the result
// register.
// synchronous active-low reset clears the device state, address and endpoint
// enable and empties both registers.
// a stalled result holds; the input stalls only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module usb_ep0_standard_request_handler (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire usb_ep0_pkg::t_req i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output usb_ep0_pkg::t_rsp      o_out_data,
    input  wire logic              i_out_stall
);

    logic              w_req_valid;
    usb_ep0_pkg::t_req w_req;
    usb_ep0_pkg::t_rsp w_rsp;
    logic              w_out_ready;
    logic              w_fire;

    // item retires from the input register into the result register
    assign w_fire = w_req_valid && w_out_ready;

    // input register
    usb_ep0_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_req     (i_in_data),
        .i_advance (w_out_ready),
        .o_stall   (o_in_stall),
        .o_valid   (w_req_valid),
        .o_req     (w_req)
    );

    // decode and device state
    usb_ep0_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // result register
    usb_ep0_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_valid),
        .i_rsp   (w_rsp),
        .i_stall (i_out_stall),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_rsp   (o_out_data)
    );

`ifndef NO_ASSERTIONS
    // input only backs up behind a stalled, full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a stalled result");

    // descriptor fields are zero unless data is sent
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action != usb_ep0_pkg::ACT_SEND) |->
        (o_out_data.descriptor_select == usb_ep0_pkg::DESC_DEVICE &&
         o_out_data.send_length == 16'd0))
        else $error("descriptor fields set without send");

    // clamped length never exceeds the longest descriptor
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.send_length <= 16'd36))
        else $error("send length beyond descriptor size");

    // a retired item always lands in the result register next cycle
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("retired item lost");
`endif

endmodule

`default_nettype wire

/* tb/sv/usb_ep0_request_checker.sv */
// checker: predicts the ep0 request handler results and compares every result transfer
`timescale 1ns / 1ps

module usb_ep0_request_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  usb_ep0_pkg::t_req i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  usb_ep0_pkg::t_rsp i_out_data,
    output int                o_fail_count,
    output int                o_pending
);
    import usb_ep0_pkg::*;

    // results owed for requests already transferred in, oldest first
    t_rsp owed_rsp_q[$];

    // shadow copy of the device registers
    t_dev_state        shadow_state;
    logic [ADDR_W-1:0] shadow_addr;
    logic              shadow_ep1_en;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // byte count of each descriptor
    function automatic logic [15:0] descriptor_bytes(input t_desc_sel sel);
        case (sel)
            DESC_DEVICE:    return 16'd18;
            DESC_CONFIG:    return 16'd32;
            DESC_LANGID:    return 16'd4;
            DESC_MAKER:     return 16'd18;
            DESC_PRODUCT:   return 16'd36;
            DESC_SERIAL:    return 16'd18;
            DESC_INTERFACE: return 16'd30;
            default:        return 16'd1;
        endcase
    endfunction

    // work out the result of one request and move the shadow registers
    task automatic predict_response(input t_req req, output t_rsp rsp);
        logic [15:0] addr16;
        logic [15:0] full_len;
        t_action     act;
        t_desc_sel   sel;
        logic [15:0] len;
        bit          known;
        addr16 = {req.value_high, req.value_low};
        act    = ACT_NONE;
        sel    = DESC_DEVICE;
        len    = '0;
        known  = 1'b0;
        if (req.func == FUNC_BUS_RESET) begin
            shadow_state  = ST_INITIAL;
            shadow_addr   = '0;
            shadow_ep1_en = 1'b0;
        end else if (req.func == FUNC_SETUP) begin
            act = ACT_IGNORE;
            case (req.request_code)
                REQ_GET_DESCRIPTOR: begin
                    if (req.value_high == DTYPE_DEVICE) begin
                        sel   = DESC_DEVICE;
                        known = 1'b1;
                    end else if (req.value_high == DTYPE_CONFIG) begin
                        sel   = DESC_CONFIG;
                        known = 1'b1;
                    end else if (req.value_high == DTYPE_STRING) begin
                        known = 1'b1;
                        case (req.value_low)
                            STR_LANGID:    sel = DESC_LANGID;
                            STR_MAKER:     sel = DESC_MAKER;
                            STR_PRODUCT:   sel = DESC_PRODUCT;
                            STR_SERIAL:    sel = DESC_SERIAL;
                            STR_INTERFACE: sel = DESC_INTERFACE;
                            default:       known = 1'b0;
                        endcase
                    end
                    if (known) begin
                        act      = ACT_SEND;
                        full_len = descriptor_bytes(sel);
                        len      = (full_len < req.request_length) ? full_len
                                                                   : req.request_length;
                    end
                end
                REQ_SET_ADDRESS: begin
                    if (req.request_index == 16'd0 && req.request_length == 16'd0 &&
                            addr16 < ADDR_LIMIT) begin
                        case (shadow_state)
                            ST_INITIAL: begin
                                act = ACT_ACK;
                                if (addr16 != 16'd0) begin
                                    shadow_addr  = addr16[ADDR_W-1:0];
                                    shadow_state = ST_CONFIGURED;
                                end
                            end
                            ST_UNCONFIGURED: begin
                                act = ACT_ACK;
                                shadow_addr = addr16[ADDR_W-1:0];
                                if (addr16 == 16'd0) shadow_state = ST_INITIAL;
                            end
                            ST_CONFIGURED: begin
                                if (addr16 == 16'd0) begin
                                    act          = ACT_ACK;
                                    shadow_addr  = '0;
                                    shadow_state = ST_INITIAL;
                                end else begin
                                    act = ACT_ACK_IGNORE;
                                end
                            end
                            default: act = ACT_NONE;
                        endcase
                    end
                end
                REQ_GET_CONFIG: begin
                    if (shadow_state == ST_CONFIGURED && req.value_high == 8'd0 &&
                            req.value_low == 8'd0 && req.request_index == 16'd0 &&
                            req.request_length[7:0] == 8'd1) begin
                        act = ACT_SEND;
                        sel = DESC_CFG_VALUE;
                        len = 16'd1;
                    end
                end
                REQ_SET_CONFIG: begin
                    if (req.request_index == 16'd0 && req.request_length == 16'd0 &&
                            req.request_type == 8'd0 && req.value_high == 8'd0) begin
                        if (shadow_state == ST_UNCONFIGURED) begin
                            if (req.value_low == 8'd1) begin
                                shadow_ep1_en = 1'b1;
                                shadow_state  = ST_CONFIGURED;
                                act           = ACT_ACK;
                            end else if (req.value_low == 8'd0) begin
                                act = ACT_ACK;
                            end
                        end else if (shadow_state == ST_CONFIGURED) begin
                            if (req.value_low == 8'd1) begin
                                act = ACT_ACK;
                            end else if (req.value_low == 8'd0) begin
                                shadow_ep1_en = 1'b0;
                                shadow_state  = ST_UNCONFIGURED;
                                act           = ACT_ACK;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        rsp.action                = act;
        rsp.descriptor_select     = sel;
        rsp.send_length           = len;
        rsp.device_address        = shadow_addr;
        rsp.device_state          = shadow_state;
        rsp.data_endpoint_enabled = shadow_ep1_en;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            shadow_state  = ST_INITIAL;
            shadow_addr   = '0;
            shadow_ep1_en = 1'b0;
            owed_rsp_q.delete();
        end else begin
            // result transfer against the oldest owed result
            if (i_out_valid && !i_out_stall) begin
                if (owed_rsp_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = owed_rsp_q.pop_front();
                    compare_field("action", 16'(want.action), 16'(i_out_data.action));
                    compare_field("descriptor_select", 16'(want.descriptor_select),
                                  16'(i_out_data.descriptor_select));
                    compare_field("send_length", want.send_length, i_out_data.send_length);
                    compare_field("device_address", 16'(want.device_address),
                                  16'(i_out_data.device_address));
                    compare_field("device_state", 16'(want.device_state),
                                  16'(i_out_data.device_state));
                    compare_field("data_endpoint_enabled", 16'(want.data_endpoint_enabled),
                                  16'(i_out_data.data_endpoint_enabled));
                end
            end
            // request transfer
            if (i_in_valid && !i_in_stall) begin
                predict_response(i_in_data, want);
                owed_rsp_q.push_back(want);
            end
        end
        o_pending = owed_rsp_q.size();
    end

endmodule

/* tb/sv/usb_ep0_standard_request_handler_test.sv */
// testbench top: request stimulus, result stall pattern and verdict for the ep0 handler
`timescale 1ns / 1ps

module usb_ep0_standard_request_handler_test;
    import usb_ep0_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_RESERVED  = 2'd3;
    localparam logic [7:0] REQ_GET_STATUS = 8'd0;
    localparam logic [7:0] DTYPE_OTHER    = 8'd4;
    localparam logic [7:0] STR_UNUSED     = 8'd4;
    localparam logic [7:0] RT_OUT_STD     = 8'h00;
    localparam logic [7:0] RT_IN_STD      = 8'h80;

    localparam int RANDOM_ITEMS = 1950;
    localparam int QUIET_ITEMS  = 250;
    localparam int LONG_HOLD    = 60;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_rsp out_data;
    int   fail_count;
    int   pending;

    bit quiet_phase   = 1'b0;
    bit long_hold_req = 1'b0;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    usb_ep0_standard_request_handler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    usb_ep0_request_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // run limit
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_req setup_req(input logic [7:0] rtype, input logic [7:0] code,
                                       input logic [7:0] vlo, input logic [7:0] vhi,
                                       input logic [15:0] idx, input logic [15:0] len);
        t_req req;
        req.func           = FUNC_SETUP;
        req.request_type   = rtype;
        req.request_code   = code;
        req.value_low      = vlo;
        req.value_high     = vhi;
        req.request_index  = idx;
        req.request_length = len;
        return req;
    endfunction

    // mostly well-formed requests with random content, some noise and broken ones
    function automatic t_req random_request();
        t_req req;
        int   pick;
        bit   shaped;
        req = setup_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        16'($urandom), 16'($urandom));
        pick   = $urandom_range(0, 99);
        shaped = 1'b0;
        if (pick < 6) begin
            req.func = FUNC_BUS_RESET;
        end else if (pick < 10) begin
            req.func = ($urandom_range(0, 1) != 0) ? FUNC_EMPTY : FUNC_RESERVED;
        end else if (pick < 18) begin
            req.func = 2'($urandom);
        end else if (pick < 42) begin
            req.request_code = REQ_GET_DESCRIPTOR;
            case ($urandom_range(0, 4))
                0:       req.value_high = DTYPE_DEVICE;
                1:       req.value_high = DTYPE_CONFIG;
                2, 3:    req.value_high = DTYPE_STRING;
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0) req.value_low = 8'($urandom_range(0, 6));
            if ($urandom_range(0, 2) != 0) req.request_length = 16'($urandom_range(0, 48));
        end else if (pick < 60) begin
            req.request_code  = REQ_SET_ADDRESS;
            req.request_index = '0;
            req.request_length = '0;
            req.value_high    = '0;
            if ($urandom_range(0, 3) == 0) req.value_low = '0;
            shaped = 1'b1;
        end else if (pick < 70) begin
            req.request_code        = REQ_GET_CONFIG;
            req.request_type        = RT_IN_STD;
            req.value_low           = '0;
            req.value_high          = '0;
            req.request_index       = '0;
            req.request_length[7:0] = 8'd1;
            shaped = 1'b1;
        end else if (pick < 92) begin
            req.request_code   = REQ_SET_CONFIG;
            req.request_type   = RT_OUT_STD;
            req.value_high     = '0;
            req.request_index  = '0;
            req.request_length = '0;
            if ($urandom_range(0, 3) != 0) req.value_low = 8'($urandom_range(0, 1));
            shaped = 1'b1;
        end
        // break one field of a well-formed request now and then
        if (shaped && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
                0: req.request_index  ^= 16'(1 << $urandom_range(0, 15));
                1: req.request_length ^= 16'(1 << $urandom_range(0, 15));
                2: req.value_high     ^= 8'(1 << $urandom_range(0, 7));
                3: req.request_type   ^= 8'(1 << $urandom_range(0, 7));
                default: req.value_low ^= 8'(1 << $urandom_range(0, 7));
            endcase
        end
        return req;
    endfunction

    // offer one request from a falling edge until it is transferred
    task automatic send_item(input t_req req);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // result side stall pattern
    initial begin : result_stall
        int hold_cycles;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                out_stall = 1'b1;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(negedge clk);
                out_stall     = 1'b0;
                long_hold_req = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        t_req directed_q[$];
        t_req bus_reset;
        int   item_no;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // bus reset with all other bits set
        bus_reset      = '1;
        bus_reset.func = FUNC_BUS_RESET;
        directed_q.push_back(bus_reset);
        // requests refused in the initial state, zero address accepted
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_CONFIG, 8'd0, 8'd0, 16'd0, 16'd1));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_CONFIG, 8'd1, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_ADDRESS, 8'd0, 8'd0, 16'd0, 16'd0));
        // descriptors: zero length, full length, clamped
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, 8'd0, DTYPE_DEVICE,
                                       16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, 8'd0, DTYPE_DEVICE,
                                       16'hffff, 16'hffff));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, 8'd0, DTYPE_CONFIG,
                                       16'd0, 16'd9));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, STR_LANGID, DTYPE_STRING,
                                       16'd0, 16'hffff));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, STR_MAKER, DTYPE_STRING,
                                       16'd0, 16'hffff));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, STR_PRODUCT, DTYPE_STRING,
                                       16'd0, 16'hffff));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, STR_SERIAL, DTYPE_STRING,
                                       16'd0, 16'hffff));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, STR_UNUSED, DTYPE_STRING,
                                       16'd0, 16'hffff));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, STR_INTERFACE,
                                       DTYPE_STRING, 16'd0, 16'd10));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_DESCRIPTOR, 8'd0, DTYPE_OTHER,
                                       16'd0, 16'hffff));
        // address at the limit is refused, one below it is taken
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_ADDRESS, 8'hff, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_ADDRESS, 8'hfe, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_ADDRESS, 8'd3, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_CONFIG, 8'd0, 8'd0, 16'd0, 16'hff01));
        // configuration moves, high byte of the value must be zero
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_CONFIG, 8'd0, 8'hff, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_CONFIG, 8'd0, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_CONFIG, 8'd0, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_ADDRESS, 8'h81, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_CONFIG, 8'd1, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_CONFIG, 8'd0, 8'd0, 16'd0, 16'd0));
        directed_q.push_back(setup_req(RT_OUT_STD, REQ_SET_ADDRESS, 8'd0, 8'd0, 16'd0, 16'd0));
        // empty packet, reserved kind, unknown request
        bus_reset      = '1;
        bus_reset.func = FUNC_EMPTY;
        directed_q.push_back(bus_reset);
        bus_reset.func = FUNC_RESERVED;
        directed_q.push_back(bus_reset);
        directed_q.push_back(setup_req(RT_IN_STD, REQ_GET_STATUS, 8'd0, 8'd0, 16'd0, 16'd2));
        foreach (directed_q[i]) send_item(directed_q[i]);

        for (item_no = 0; item_no < RANDOM_ITEMS; item_no++) begin
            if (item_no == 600) long_hold_req = 1'b1;
            // sender waits until every owed result is back
            if (item_no == 1200) begin
                in_valid = 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (item_no == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
            send_item(random_request());
        end
        in_valid = 1'b0;

        // drain, then keep watching for stray results before the verdict
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
